// ===== design/cqo_pkg.sv =====
`timescale 1ns / 1ps

package cqo_pkg;

  localparam int DEF_MAX_ORBIT_STEPS = 63;
  localparam int DEF_FRACTION_BITS   = 20;

  localparam int STEP_W     = 6;
  localparam int LIMIT_W    = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [STEP_W-1:0]  MAX_STEPS_RESET    = 6'd63;
  localparam logic [LIMIT_W-1:0] ESCAPE_LIMIT_RESET = 23'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_LIMIT = 2'd1;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
  } in_t;

  typedef struct packed {
    logic signed [31:0] point_real;
    logic signed [31:0] point_imag;
    logic [STEP_W-1:0]  step_index;
    logic               last;
    logic               escaped;
  } out_t;

  // Clamp a wide signed sum to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = 65'sh0_7FFF_FFFF;
    lo = -65'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== design/complex_quadratic_orbit.sv =====
`timescale 1ns / 1ps
// The start point appears in the cycle after a point is accepted; each further orbit
// point passes through the states CROSS, UPD, SQR, SQI and CHK in turn, as the single
// shared 32x32 multiplier (cross product, two squares) has a state per product.
// A new point is accepted only when idle, after the orbit (at most 63 iterations) ends.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset (rst_n low, synchronous) returns to idle: max_steps = 63, escape_limit = 1000.
module complex_quadratic_orbit #(
  parameter int MAX_ORBIT_STEPS = cqo_pkg::DEF_MAX_ORBIT_STEPS,
  parameter int FRACTION_BITS   = cqo_pkg::DEF_FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  cqo_pkg::in_t                   in_data,
  output logic                           out_valid,
  output cqo_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cqo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cqo_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int STEP_W  = cqo_pkg::STEP_W;
  localparam int LIMIT_W = cqo_pkg::LIMIT_W;
  localparam int SHIFT2F = 2 * FRACTION_BITS;
  localparam int CMP_W   = (LIMIT_W + SHIFT2F > 64) ? LIMIT_W + SHIFT2F : 64;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CROSS = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SQR   = 3'd3;
  localparam logic [2:0] S_SQI   = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [STEP_W-1:0]        max_steps_r;
  logic [LIMIT_W-1:0]       esc_limit_r;
  logic [STEP_W-1:0]        lim_r, lim_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic signed [31:0]       cre_r, cim_r, cre_nxt, cim_nxt;
  logic signed [31:0]       re_r, im_r, re_nxt, im_nxt;
  logic signed [63:0]       prod_r, prod_nxt;
  logic signed [63:0]       acc_r, acc_nxt;
  logic signed [63:0]       re2_r, re2_nxt;
  logic signed [63:0]       im2_r, im2_nxt;
  logic                     out_valid_r, out_valid_nxt;
  cqo_pkg::out_t            out_data_r, out_data_nxt;

  logic signed [31:0]       mul_a, mul_b;
  logic signed [63:0]       mul_p;
  logic signed [64:0]       re_sum, im_sum;
  logic [63:0]              mag;
  logic [CMP_W-1:0]         mag_ext, lim_ext;
  logic                     esc;
  logic [STEP_W-1:0]        step_inc;
  logic [STEP_W-1:0]        lim_cfg;
  logic                     accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign lim_cfg = (max_steps_r > STEP_W'(MAX_ORBIT_STEPS)) ?
                   STEP_W'(MAX_ORBIT_STEPS) : max_steps_r;

  // The one multiplier, shared over the steps of an iteration.
  always_comb begin
    unique case (state_r)
      S_SQR:   begin mul_a = re_r; mul_b = re_r; end
      S_SQI:   begin mul_a = im_r; mul_b = im_r; end
      default: begin mul_a = re_r; mul_b = im_r; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Arithmetic right shifts round toward minus infinity.
  assign re_sum = 65'(acc_r >>> FRACTION_BITS) + 65'(cre_r);
  assign im_sum = 65'(prod_r >>> (FRACTION_BITS - 1)) + 65'(cim_r);

  // Both squares are nonnegative, so the sum fits 64 unsigned bits.
  assign mag     = unsigned'(re2_r) + unsigned'(prod_r);
  assign mag_ext = CMP_W'(mag);
  assign lim_ext = CMP_W'(esc_limit_r) << SHIFT2F;
  assign esc     = (mag_ext > lim_ext);
  assign step_inc = step_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    lim_nxt       = lim_r;
    step_nxt      = step_r;
    cre_nxt       = cre_r;
    cim_nxt       = cim_r;
    re_nxt        = re_r;
    im_nxt        = im_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    re2_nxt       = re2_r;
    im2_nxt       = im2_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cre_nxt  = in_data.c_real;
          cim_nxt  = in_data.c_imag;
          re_nxt   = '0;
          im_nxt   = '0;
          re2_nxt  = '0;
          im2_nxt  = '0;
          lim_nxt  = lim_cfg;
          step_nxt = '0;
          out_valid_nxt           = 1'b1;
          out_data_nxt.point_real = '0;
          out_data_nxt.point_imag = '0;
          out_data_nxt.step_index = '0;
          out_data_nxt.last       = (lim_cfg == '0);
          out_data_nxt.escaped    = 1'b0;
          state_nxt = (lim_cfg == '0) ? S_IDLE : S_CROSS;
        end
      end
      S_CROSS: begin
        prod_nxt  = mul_p;
        acc_nxt   = re2_r - im2_r;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        re_nxt    = cqo_pkg::sat32(re_sum);
        im_nxt    = cqo_pkg::sat32(im_sum);
        state_nxt = S_SQR;
      end
      S_SQR: begin
        prod_nxt  = mul_p;
        state_nxt = S_SQI;
      end
      S_SQI: begin
        re2_nxt   = prod_r;
        prod_nxt  = mul_p;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // The squares are kept for the next iteration's real part.
        im2_nxt  = prod_r;
        step_nxt = step_inc;
        out_valid_nxt           = 1'b1;
        out_data_nxt.point_real = re_r;
        out_data_nxt.point_imag = im_r;
        out_data_nxt.step_index = step_inc;
        out_data_nxt.last       = esc || (step_inc == lim_r);
        out_data_nxt.escaped    = esc;
        state_nxt = (esc || (step_inc == lim_r)) ? S_IDLE : S_CROSS;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      max_steps_r <= cqo_pkg::MAX_STEPS_RESET;
      esc_limit_r <= cqo_pkg::ESCAPE_LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        priority if (cfg_index == cqo_pkg::REG_MAX_STEPS) begin
          max_steps_r <= cfg_data[STEP_W-1:0];
        end else if (cfg_index == cqo_pkg::REG_ESCAPE_LIMIT) begin
          esc_limit_r <= cfg_data[LIMIT_W-1:0];
        end else begin
          max_steps_r <= max_steps_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    lim_r      <= lim_nxt;
    step_r     <= step_nxt;
    cre_r      <= cre_nxt;
    cim_r      <= cim_nxt;
    re_r       <= re_nxt;
    im_r       <= im_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    re2_r      <= re2_nxt;
    im2_r      <= im2_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
